>>> design/tmms_pkg.sv
// ----------------------------------------------------------------------------
// tmms_pkg
// Types, codes and helpers shared by the two-motor move sequencer.
// ----------------------------------------------------------------------------
package tmms_pkg;

   localparam int COUNT_BITS_DEF = 32;
   localparam int SPEED_W        = 8;
   localparam int AMOUNT_W       = 32;
   localparam int DUTY_W         = 12;
   localparam int WORD_W         = 13;
   localparam int CPC_W          = 16;
   localparam int CSR_ADDR_W     = 2;
   localparam int CSR_DATA_W     = 32;
   localparam int NUM_CH         = 4;

   localparam logic [CPC_W-1:0]      CPC_RESET  = 16'd30;
   localparam logic [DUTY_W-1:0]     DUTY_FULL  = 12'd4095;
   localparam logic [WORD_W-1:0]     WORD_FULL  = 13'd4096;
   localparam logic [CSR_ADDR_W-1:0] ADDR_CPC   = 2'd0;

   typedef enum logic [2:0] {
      OP_TICK   = 3'd0,
      OP_ENC1   = 3'd1,
      OP_ENC2   = 3'd2,
      OP_STOP   = 3'd3,
      OP_DRIVE  = 3'd4,
      OP_DIST   = 3'd5,
      OP_TIMED  = 3'd6,
      OP_ROTATE = 3'd7
   } op_type;

   typedef struct packed {
      op_type                opcode;
      logic [SPEED_W-1:0]    speed;
      logic                  reverse;
      logic [AMOUNT_W-1:0]   amount;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] on_time;
      logic [WORD_W-1:0] off_time;
   } word_pair_type;

   typedef struct packed {
      word_pair_type [NUM_CH-1:0] ch;
      logic                       moving;
      logic                       stopped_now;
   } rsp_type;

   function automatic word_pair_type encode_duty(input logic [DUTY_W-1:0] d);
      word_pair_type w;
      if (d >= DUTY_FULL) begin
         w.on_time  = WORD_FULL;
         w.off_time = '0;
      end else if (d == '0) begin
         w.on_time  = '0;
         w.off_time = WORD_FULL;
      end else begin
         w.on_time  = {1'b0, DUTY_FULL - d};
         w.off_time = '0;
      end
      return w;
   endfunction

endpackage

>>> design/tmms_csr.sv
// ----------------------------------------------------------------------------
// tmms_csr
// Register port holding the encoder counts per centimetre.
// ----------------------------------------------------------------------------
module tmms_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tmms_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [tmms_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tmms_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output logic [tmms_pkg::CPC_W-1:0]        counts_per_cm
);
   import tmms_pkg::*;

   logic [CPC_W-1:0] cpc_ff;
   logic [CPC_W-1:0] cpc_in;
   logic             wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit = csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr == ADDR_CPC);

   always_comb begin
      cpc_in = cpc_ff;
      if (wr_hit) begin
         cpc_in = csr_pwdata[CPC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cpc_ff <= CPC_RESET;
      end else begin
         cpc_ff <= cpc_in;
      end
   end

   assign csr_prdata = (csr_paddr == ADDR_CPC) ?
                       {{(CSR_DATA_W-CPC_W){1'b0}}, cpc_ff} : '0;
   assign counts_per_cm = cpc_ff;

endmodule

>>> design/tmms_in_stage.sv
// ----------------------------------------------------------------------------
// tmms_in_stage
// Input register for requests; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module tmms_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  tmms_pkg::req_type  req_item,
   input  logic               take,
   output logic               item_valid,
   output tmms_pkg::req_type  item
);
   import tmms_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;
   req_type item_in;

   assign req_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_ready) begin
         valid_in = req_valid;
         item_in  = req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> design/tmms_core.sv
// ----------------------------------------------------------------------------
// tmms_core
// Move state, next-state logic and the result register.
// ----------------------------------------------------------------------------
module tmms_core #(
   parameter int COUNT_BITS = tmms_pkg::COUNT_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        item_valid,
   input  tmms_pkg::req_type           item,
   input  logic [tmms_pkg::CPC_W-1:0]  counts_per_cm,
   output logic                        take,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output tmms_pkg::rsp_type           rsp
);
   import tmms_pkg::*;

   localparam int PROD_W = CPC_W + AMOUNT_W;

   logic [COUNT_BITS-1:0]           cnt1_ff, cnt1_in, cnt2_ff, cnt2_in;
   logic [COUNT_BITS-1:0]           target_ff, target_in;
   logic                            dist_armed_ff, dist_armed_in;
   logic [AMOUNT_W-1:0]             time_left_ff, time_left_in;
   logic                            time_armed_ff, time_armed_in;
   logic [NUM_CH-1:0][DUTY_W-1:0]   duty_ff, duty_in;
   logic                            out_valid_ff, out_valid_in;
   rsp_type                         rsp_ff, rsp_in;

   logic [DUTY_W-1:0]               duty;
   logic [PROD_W-1:0]               prod;
   logic [COUNT_BITS+PROD_W-1:0]    prod_ext;
   logic [COUNT_BITS-1:0]           cnt1_inc, cnt2_inc;
   logic [AMOUNT_W-1:0]             time_dec;
   logic                            zero_move;
   logic                            halt;

   assign take = item_valid && (!out_valid_ff || rsp_ready);

   assign duty      = {item.speed, 4'b0000};
   assign prod      = PROD_W'(counts_per_cm) * PROD_W'(item.amount);
   assign prod_ext  = {{COUNT_BITS{1'b0}}, prod};
   assign cnt1_inc  = cnt1_ff + COUNT_BITS'(1);
   assign cnt2_inc  = cnt2_ff + COUNT_BITS'(1);
   assign time_dec  = (time_left_ff != '0) ? time_left_ff - AMOUNT_W'(1) : time_left_ff;
   assign zero_move = (item.amount == '0) || (item.speed == '0);

   always_comb begin
      cnt1_in       = cnt1_ff;
      cnt2_in       = cnt2_ff;
      target_in     = target_ff;
      dist_armed_in = dist_armed_ff;
      time_left_in  = time_left_ff;
      time_armed_in = time_armed_ff;
      duty_in       = duty_ff;
      halt          = 1'b0;
      case (item.opcode)
         OP_TICK: begin
            if (time_armed_ff) begin
               time_left_in = time_dec;
               halt = (time_dec == '0);
            end
         end
         OP_ENC1: begin
            cnt1_in = cnt1_inc;
            halt = dist_armed_ff && (cnt1_inc == target_ff);
         end
         OP_ENC2: begin
            cnt2_in = cnt2_inc;
            halt = dist_armed_ff && (cnt2_inc == target_ff);
         end
         OP_STOP: begin
            halt = 1'b1;
         end
         OP_DRIVE: begin
            dist_armed_in = 1'b0;
            time_armed_in = 1'b0;
            duty_in = item.reverse ? {duty, 12'd0, 12'd0, duty} : {12'd0, duty, duty, 12'd0};
         end
         OP_DIST: begin
            if (zero_move) begin
               halt = 1'b1;
            end else begin
               cnt1_in       = '0;
               cnt2_in       = '0;
               target_in     = prod_ext[COUNT_BITS-1:0];
               dist_armed_in = 1'b1;
               time_armed_in = 1'b0;
               duty_in = item.reverse ? {duty, 12'd0, 12'd0, duty}
                                      : {12'd0, duty, duty, 12'd0};
            end
         end
         OP_TIMED: begin
            if (zero_move) begin
               halt = 1'b1;
            end else begin
               cnt1_in       = '0;
               cnt2_in       = '0;
               dist_armed_in = 1'b0;
               time_left_in  = item.amount;
               time_armed_in = 1'b1;
               duty_in = item.reverse ? {duty, 12'd0, 12'd0, duty}
                                      : {12'd0, duty, duty, 12'd0};
            end
         end
         OP_ROTATE: begin
            if (zero_move) begin
               halt = 1'b1;
            end else begin
               dist_armed_in = 1'b0;
               time_left_in  = item.amount;
               time_armed_in = 1'b1;
               duty_in = item.reverse ? {duty, 12'd0, duty, 12'd0}
                                      : {12'd0, duty, 12'd0, duty};
            end
         end
         default: begin
            halt = 1'b0;
         end
      endcase
      if (halt) begin
         dist_armed_in = 1'b0;
         time_armed_in = 1'b0;
         duty_in       = '0;
      end
      // channel index 3 is m1a, down to 0 for m2b
      rsp_in.ch[3]       = encode_duty(duty_in[3]);
      rsp_in.ch[2]       = encode_duty(duty_in[2]);
      rsp_in.ch[1]       = encode_duty(duty_in[1]);
      rsp_in.ch[0]       = encode_duty(duty_in[0]);
      rsp_in.moving      = |duty_in;
      rsp_in.stopped_now = (|duty_ff) && !(|duty_in);

      out_valid_in = out_valid_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (take) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt1_ff       <= '0;
         cnt2_ff       <= '0;
         target_ff     <= '0;
         dist_armed_ff <= 1'b0;
         time_left_ff  <= '0;
         time_armed_ff <= 1'b0;
         duty_ff       <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (take) begin
            cnt1_ff       <= cnt1_in;
            cnt2_ff       <= cnt2_in;
            target_ff     <= target_in;
            dist_armed_ff <= dist_armed_in;
            time_left_ff  <= time_left_in;
            time_armed_ff <= time_armed_in;
            duty_ff       <= duty_in;
         end
         out_valid_ff <= out_valid_in;
      end
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = rsp_ff;

   a_arms_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(dist_armed_ff && time_armed_ff))
      else $error("distance and time both armed");

   a_moving_matches: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (rsp_ff.moving == (|duty_ff)))
      else $error("moving flag disagrees with duties");

   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      (take && item.opcode == OP_STOP) |=>
      (!dist_armed_ff && !time_armed_ff && duty_ff == '0))
      else $error("stop left the drive active");

   a_dist_start: assert property (@(posedge clock) disable iff (reset)
      (take && item.opcode == OP_DIST && !zero_move) |=>
      (cnt1_ff == '0 && cnt2_ff == '0 && dist_armed_ff))
      else $error("distance move did not clear counts");

endmodule

>>> design/two_motor_move_sequencer.sv
// ----------------------------------------------------------------------------
// two_motor_move_sequencer
// Command, tick and encoder sequencer for a two-motor H-bridge drive.
//
//   port group   direction   contents
//   req_*        in          opcode (tuser), speed/reverse/amount (tdata)
//   rsp_*        out         four channel on/off words, moving, stopped_now
//   csr_*        in/out      counts_per_cm at byte address 0
//
// one request per cycle while the result is not stalled
// input register, then state update and result register in one pass
// reset clears counts, arms, duties and both valid flags
// a stalled result holds; one further request waits in the input register
// ----------------------------------------------------------------------------
module two_motor_move_sequencer #(
   parameter int COUNT_BITS = tmms_pkg::COUNT_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // speed [7:0], reverse [8], amount [40:9], zero fill [47:41]
   input  logic [47:0]                       req_tdata,
   // opcode [2:0]
   input  logic [2:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // m1a_on, m1a_off, m1b_on, m1b_off, m2a_on, m2a_off, m2b_on, m2b_off
   // (13 bits each from bit 0), moving [104], stopped_now [105], zero fill
   output logic [111:0]                      rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tmms_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [tmms_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tmms_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import tmms_pkg::*;

   req_type           req_item;
   req_type           item;
   rsp_type           rsp;
   logic              item_valid;
   logic              take;
   logic [CPC_W-1:0]  counts_per_cm;

   assign req_item.opcode  = op_type'(req_tuser);
   assign req_item.speed   = req_tdata[7:0];
   assign req_item.reverse = req_tdata[8];
   assign req_item.amount  = req_tdata[40:9];

   tmms_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .counts_per_cm (counts_per_cm)
   );

   tmms_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   tmms_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (item_valid),
      .item          (item),
      .counts_per_cm (counts_per_cm),
      .take          (take),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp           (rsp)
   );

   assign rsp_tdata = {6'd0, rsp.stopped_now, rsp.moving,
                       rsp.ch[0].off_time, rsp.ch[0].on_time,
                       rsp.ch[1].off_time, rsp.ch[1].on_time,
                       rsp.ch[2].off_time, rsp.ch[2].on_time,
                       rsp.ch[3].off_time, rsp.ch[3].on_time};

endmodule
